### rtl/core/polynomial_evaluator_core_macros.svh
// Assertion macros shared by the polynomial evaluator RTL.
`ifndef POLYNOMIAL_EVALUATOR_CORE_MACROS_SVH
`define POLYNOMIAL_EVALUATOR_CORE_MACROS_SVH

// Same-cycle implication, checked on clk and disabled while reset is active.
`define PEC_ASSERT_SAME(name, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked on clk and disabled while reset is active.
`define PEC_ASSERT_NEXT(name, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### rtl/core/poly_eval_pkg.sv
// Package with widths, register indexes and limits of the polynomial evaluator.
package poly_eval_pkg;

	// Field widths.
	localparam int X_W        = 21;
	localparam int OUT_W      = 59;
	localparam int COEF_W     = 16;
	localparam int DEG_W      = 3;
	localparam int CFG_IDX_W  = 4;
	localparam int CFG_DATA_W = 16;

	// Shared multiplier: the accumulator is split into a low unsigned word and a
	// signed high word, each multiplied by x in its own cycle.
	localparam int LO_W       = 32;
	localparam int HI_W       = OUT_W - LO_W;
	localparam int MUL_A_W    = LO_W + 1;
	localparam int MUL_W      = MUL_A_W + X_W;
	localparam int HI_PROD_W  = HI_W + X_W;
	localparam int PROD_W     = OUT_W + X_W;

	// Default parameter values.
	localparam int MAX_DEGREE_DEF = 6;
	localparam int FRAC_BITS_DEF  = 16;

	// Configuration register indexes.
	localparam logic [CFG_IDX_W-1:0] CFG_DEGREE    = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] CFG_COEF_BASE = CFG_IDX_W'(1);

	// Saturation bounds of the result.
	localparam logic signed [OUT_W-1:0] OUT_MAX = {1'b0, {(OUT_W-1){1'b1}}};
	localparam logic signed [OUT_W-1:0] OUT_MIN = {1'b1, {(OUT_W-1){1'b0}}};

endpackage

### rtl/core/polynomial_evaluator_core.sv
// Polynomial evaluator by Horner's rule in fixed point on one shared multiplier.
//
//  channel | direction | handshake            | payload
//  --------+-----------+----------------------+----------------------------
//  in      | to core   | in_valid / in_stall  | x_value
//  out     | from core | out_valid / out_stall| poly_value, overflow
//  cfg     | to core   | cfg_valid / cfg_ready| cfg_index, cfg_data
//
// In_stall holds new items off until the sequencer is back in idle, and each Horner
// step runs through its states in order on the one 33x21 multiplier
// (low word, high word, shift and clamp, coefficient add and clamp).
// The result register parts the output from the sequencer: a new item is taken
// while an earlier result still waits under out_stall.
// Reset clears the sequencer, the result register and the configuration registers.
// cfg_ready is always high; configuration must be written only in idle, unenforced.
`include "polynomial_evaluator_core_macros.svh"

module polynomial_evaluator_core
	import poly_eval_pkg::*;
#(
	parameter int MAX_DEGREE = MAX_DEGREE_DEF,
	parameter int FRAC_BITS  = FRAC_BITS_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	// Input items.
	input  logic                         in_valid,
	output logic                         in_stall,
	input  logic signed [X_W-1:0]        x_value,
	// Result items.
	output logic                         out_valid,
	input  logic                         out_stall,
	output logic signed [OUT_W-1:0]      poly_value,
	output logic                         overflow,
	// Configuration writes.
	input  logic                         cfg_valid,
	output logic                         cfg_ready,
	input  logic [CFG_IDX_W-1:0]         cfg_index,
	input  logic [CFG_DATA_W-1:0]        cfg_data
);

	localparam int NUM_COEF = MAX_DEGREE + 1;
	localparam int CNT_W    = $clog2(NUM_COEF);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MUL_LO,
		ST_MUL_HI,
		ST_SUM,
		ST_ADD,
		ST_FINISH
	} state_t;

	state_t                      state_q;
	logic [DEG_W-1:0]            degree_q;
	logic signed [COEF_W-1:0]    coef_q [NUM_COEF];
	logic signed [X_W-1:0]       x_q;
	logic signed [OUT_W-1:0]     acc_q;
	logic signed [MUL_W-1:0]     mul_q;
	logic signed [PROD_W-1:0]    prod_q;
	logic signed [OUT_W-1:0]     t_q;
	logic                        ovf_q;
	logic [CNT_W-1:0]            step_q;
	logic [CNT_W-1:0]            dcnt_q;
	logic                        out_valid_q;
	logic signed [OUT_W-1:0]     poly_value_q;
	logic                        overflow_q;

	logic                        in_accept;
	logic                        out_free;
	logic [CNT_W-1:0]            deg_eff;
	logic signed [OUT_W-1:0]     acc_init;
	logic signed [MUL_A_W-1:0]   mul_a;
	logic signed [MUL_W-1:0]     mul_p;
	logic signed [PROD_W-1:0]    hi_term;
	logic signed [PROD_W-1:0]    sum_p;
	logic signed [PROD_W-1:0]    shr_p;
	logic                        shr_fits;
	logic signed [OUT_W-1:0]     t_next;
	logic                        t_ovf;
	logic signed [OUT_W-1:0]     coef_sh;
	logic signed [OUT_W:0]       add_s;
	logic                        add_ovf;
	logic signed [OUT_W-1:0]     acc_next;

	assign cfg_ready  = 1'b1;
	assign in_stall   = (state_q != ST_IDLE);
	assign in_accept  = in_valid && !in_stall;
	assign out_free   = !out_valid_q || !out_stall;
	assign out_valid  = out_valid_q;
	assign poly_value = poly_value_q;
	assign overflow   = overflow_q;

	// Degree values above the supported maximum evaluate at the maximum.
	assign deg_eff  = (degree_q > DEG_W'(MAX_DEGREE)) ? CNT_W'(MAX_DEGREE)
		: degree_q[CNT_W-1:0];
	assign acc_init = OUT_W'(coef_q[0]) <<< FRAC_BITS;

	// Shared multiplier: low word is zero-extended, high word sign-extended.
	always_comb begin
		if (state_q == ST_MUL_HI) begin
			mul_a = MUL_A_W'($signed(acc_q[OUT_W-1:LO_W]));
		end else begin
			mul_a = $signed({1'b0, acc_q[LO_W-1:0]});
		end
		mul_p = mul_a * x_q;
	end

	// Combine partial products, floor-shift by the fraction bits and clamp.
	always_comb begin
		hi_term  = PROD_W'($signed(mul_q[HI_PROD_W-1:0])) <<< LO_W;
		sum_p    = prod_q + hi_term;
		shr_p    = sum_p >>> FRAC_BITS;
		shr_fits = (&shr_p[PROD_W-1:OUT_W-1]) || !(|shr_p[PROD_W-1:OUT_W-1]);
		t_ovf    = !shr_fits;
		if (shr_fits) begin
			t_next = shr_p[OUT_W-1:0];
		end else if (shr_p[PROD_W-1]) begin
			t_next = OUT_MIN;
		end else begin
			t_next = OUT_MAX;
		end
	end

	// Add the scaled coefficient and clamp.
	always_comb begin
		coef_sh = OUT_W'(coef_q[step_q]) <<< FRAC_BITS;
		add_s   = {t_q[OUT_W-1], t_q} + {coef_sh[OUT_W-1], coef_sh};
		add_ovf = (add_s[OUT_W] != add_s[OUT_W-1]);
		if (!add_ovf) begin
			acc_next = add_s[OUT_W-1:0];
		end else if (add_s[OUT_W]) begin
			acc_next = OUT_MIN;
		end else begin
			acc_next = OUT_MAX;
		end
	end

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			degree_q <= '0;
			for (int k = 0; k < NUM_COEF; k++) begin
				coef_q[k] <= '0;
			end
		end else if (cfg_valid && cfg_ready) begin
			if (cfg_index == CFG_DEGREE) begin
				degree_q <= cfg_data[DEG_W-1:0];
			end
			for (int k = 0; k < NUM_COEF; k++) begin
				if (cfg_index == CFG_COEF_BASE + CFG_IDX_W'(k)) begin
					coef_q[k] <= $signed(cfg_data[COEF_W-1:0]);
				end
			end
		end
	end

	// Sequencer with its datapath and result registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			x_q          <= '0;
			acc_q        <= '0;
			mul_q        <= '0;
			prod_q       <= '0;
			t_q          <= '0;
			ovf_q        <= 1'b0;
			step_q       <= '0;
			dcnt_q       <= '0;
			out_valid_q  <= 1'b0;
			poly_value_q <= '0;
			overflow_q   <= 1'b0;
		end else begin
			// A taken result is dropped unless the finishing item replaces it.
			if (out_valid_q && !out_stall && state_q != ST_FINISH) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (in_accept) begin
						x_q    <= x_value;
						acc_q  <= acc_init;
						ovf_q  <= 1'b0;
						step_q <= CNT_W'(1);
						dcnt_q <= deg_eff;
						state_q <= (deg_eff == '0) ? ST_FINISH : ST_MUL_LO;
					end
				end
				ST_MUL_LO: begin
					mul_q   <= mul_p;
					state_q <= ST_MUL_HI;
				end
				ST_MUL_HI: begin
					prod_q  <= PROD_W'(mul_q);
					mul_q   <= mul_p;
					state_q <= ST_SUM;
				end
				ST_SUM: begin
					t_q     <= t_next;
					ovf_q   <= ovf_q | t_ovf;
					state_q <= ST_ADD;
				end
				ST_ADD: begin
					acc_q <= acc_next;
					ovf_q <= ovf_q | add_ovf;
					if (step_q == dcnt_q) begin
						state_q <= ST_FINISH;
					end else begin
						step_q  <= step_q + CNT_W'(1);
						state_q <= ST_MUL_LO;
					end
				end
				ST_FINISH: begin
					if (out_free) begin
						out_valid_q  <= 1'b1;
						poly_value_q <= acc_q;
						overflow_q   <= ovf_q;
						state_q      <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Checks on the sequencer.
	`PEC_ASSERT_SAME(a_step_in_range, state_q != ST_IDLE && dcnt_q != '0, step_q <= dcnt_q, "step beyond degree")
	`PEC_ASSERT_SAME(a_deg_limit, state_q != ST_IDLE, dcnt_q <= CNT_W'(MAX_DEGREE), "degree too big")
	`PEC_ASSERT_NEXT(a_finish_hands_off, state_q == ST_FINISH && out_free, out_valid && state_q == ST_IDLE, "finished item not delivered")
	`PEC_ASSERT_NEXT(a_ovf_cleared, in_accept, !ovf_q && step_q == CNT_W'(1), "item start not clean")

endmodule
